FILE: rtl/core/bhtu_pkg.sv
// Shared constants and types of the branch history table update block.
package bhtu_pkg;

  localparam int unsigned IndexBits   = 10;
  localparam int unsigned HistoryBits = 4;
  localparam int unsigned TableDepth  = 1 << IndexBits;

  localparam int unsigned PcWidth     = 32;
  localparam int unsigned HistWidth   = 10;
  localparam int unsigned CtrWidth    = 2;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDatWidth = 2;

  // index_mode register codes
  localparam logic [1:0] IDX_MODE_PC     = 2'd0;
  localparam logic [1:0] IDX_MODE_GSHARE = 2'd1;
  localparam logic [1:0] IDX_MODE_CONCAT = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_INDEX_MODE   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_ONE_BIT_MODE = 2'd1;

  // counter values
  localparam logic [CtrWidth-1:0] CTR_MAX        = 2'd3;
  localparam logic [CtrWidth-1:0] CTR_MIN        = 2'd0;
  localparam logic [CtrWidth-1:0] CTR_NEW_TAKEN  = 2'd2;
  localparam logic [CtrWidth-1:0] CTR_NEW_NTAKEN = 2'd1;

  typedef logic [IndexBits-1:0] bhtu_idx_t;

  typedef struct packed {
    logic                valid;
    logic [CtrWidth-1:0] ctr;
  } bhtu_entry_t;

  typedef struct packed {
    logic        en;
    bhtu_idx_t   addr;
    bhtu_entry_t entry;
  } bhtu_wr_t;

  typedef struct packed {
    logic      en;
    bhtu_idx_t addr;
  } bhtu_rd_t;

endpackage

FILE: rtl/core/bhtu_index.sv
// Table index formation from pc and global history.
module bhtu_index import bhtu_pkg::*; (
  input  logic [1:0]           index_mode_i,
  input  logic [PcWidth-1:0]   branch_pc_i,
  input  logic [HistWidth-1:0] history_bits_i,
  output bhtu_idx_t            index_o
);

  localparam int unsigned WordWidth = PcWidth - 2;

  logic [WordWidth-1:0]             word;
  logic [WordWidth-1:0]             gshare;
  logic [WordWidth+HistoryBits-1:0] concat;

  assign word   = branch_pc_i[PcWidth-1:2];
  assign gshare = word ^ {{(WordWidth-HistWidth){1'b0}}, history_bits_i};
  assign concat = {word, history_bits_i[HistoryBits-1:0]};

  always_comb begin
    case (index_mode_i)
      IDX_MODE_GSHARE: index_o = gshare[IndexBits-1:0];
      IDX_MODE_CONCAT: index_o = concat[IndexBits-1:0];
      // unused code indexes by pc, as pc mode does
      default:         index_o = word[IndexBits-1:0];
    endcase
  end

endmodule

FILE: rtl/core/bhtu_table.sv
// Entry memory with a clearing sweep after reset.
module bhtu_table import bhtu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bhtu_rd_t    rd_i,
  output bhtu_entry_t rd_data_o,
  input  bhtu_wr_t    wr_i,
  output logic        busy_o
);

  bhtu_entry_t mem [TableDepth];
  bhtu_entry_t rd_data_q;
  logic        busy_q, busy_d;
  bhtu_idx_t   clr_addr_q, clr_addr_d;

  always_comb begin
    busy_d     = busy_q;
    clr_addr_d = clr_addr_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.entry;
    end
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

FILE: rtl/core/branch_history_table_update.sv
// Top level of the branch history table update block.
//
// Usage: one resolved branch (pc, global history, taken) enters on the in
// channel per cycle while in_ready_o is high; the updated two-bit counter
// of its table entry leaves on the out channel. Both channels use
// valid/ready. Configuration writes (index 0: index_mode, index 1:
// one_bit_mode) go over the cfg channel, which is always ready; the user
// must make them only while the block is idle, which the block does not
// enforce. An accepted item waits in the read stage, then its counter is
// registered in the result register. Throughput is one item per cycle
// while the out channel takes results, set by the single read-modify-write
// of the entry memory; a back-to-back update of the same entry is forwarded
// from the last write. Reset: control registers clear, then a sweep
// invalidates every entry, one per cycle, with in_ready_o held low.
// Stall: when the receiver holds out_ready_i low, the result register and
// one item in the read stage are held; in_ready_o drops once both are full.
module branch_history_table_update import bhtu_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CfgDatWidth-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [PcWidth-1:0]     branch_pc_i,
  input  logic [HistWidth-1:0]   history_bits_i,
  input  logic                   outcome_taken_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CtrWidth-1:0]    new_counter_o
);

  function automatic logic [CtrWidth-1:0] next_ctr(bhtu_entry_t e, logic taken,
                                                    logic one_bit);
    logic [CtrWidth-1:0] c;
    c = e.ctr;
    if (!e.valid) begin
      c = taken ? CTR_NEW_TAKEN : CTR_NEW_NTAKEN;
    end else if (one_bit) begin
      c = taken ? CTR_MAX : CTR_MIN;
    end else if (taken) begin
      if (e.ctr != CTR_MAX) c = e.ctr + 1'b1;
    end else begin
      if (e.ctr != CTR_MIN) c = e.ctr - 1'b1;
    end
    return c;
  endfunction

  logic [1:0]          index_mode_q;
  logic                one_bit_q;
  logic                s1_valid_q;
  bhtu_idx_t           s1_idx_q;
  logic                s1_taken_q;
  logic                fwd_valid_q;
  bhtu_idx_t           fwd_idx_q;
  bhtu_entry_t         fwd_entry_q;
  logic                out_valid_q, out_valid_d;
  logic [CtrWidth-1:0] out_ctr_q;

  bhtu_idx_t           in_idx;
  bhtu_rd_t            rd;
  bhtu_wr_t            wr;
  bhtu_entry_t         rd_data;
  bhtu_entry_t         entry_cur;
  logic [CtrWidth-1:0] ctr_new;
  logic                busy;
  logic                in_fire;
  logic                s1_move;

  bhtu_index u_index (
    .index_mode_i   (index_mode_q),
    .branch_pc_i    (branch_pc_i),
    .history_bits_i (history_bits_i),
    .index_o        (in_idx)
  );

  bhtu_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd),
    .rd_data_o (rd_data),
    .wr_i      (wr),
    .busy_o    (busy)
  );

  assign cfg_ready_o = 1'b1;
  assign s1_move     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !busy && (!s1_valid_q || s1_move);
  assign in_fire     = in_valid_i && in_ready_o;

  assign rd.en   = in_fire;
  assign rd.addr = in_idx;

  // take the latest write when the memory read went out before it landed
  assign entry_cur = (fwd_valid_q && (fwd_idx_q == s1_idx_q)) ? fwd_entry_q : rd_data;
  assign ctr_new   = next_ctr(entry_cur, s1_taken_q, one_bit_q);

  assign wr.en          = s1_move;
  assign wr.addr        = s1_idx_q;
  assign wr.entry.valid = 1'b1;
  assign wr.entry.ctr   = ctr_new;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_mode_q <= IDX_MODE_PC;
      one_bit_q    <= 1'b0;
      s1_valid_q   <= 1'b0;
      fwd_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_INDEX_MODE:   index_mode_q <= cfg_data_i[1:0];
          CFG_ONE_BIT_MODE: one_bit_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        fwd_valid_q <= 1'b1;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_idx_q   <= in_idx;
      s1_taken_q <= outcome_taken_i;
    end
    if (s1_move) begin
      fwd_idx_q   <= s1_idx_q;
      fwd_entry_q <= wr.entry;
      out_ctr_q   <= ctr_new;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign new_counter_o = out_ctr_q;

`ifndef SYNTHESIS
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o)
    else $error("item accepted during table sweep");

  a_full_pipe_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("item accepted with both stages held");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_o && new_counter_o == $past(ctr_new))
    else $error("result register not loaded on update");

  a_fresh_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && !entry_cur.valid |=>
      new_counter_o == ($past(s1_taken_q) ? CTR_NEW_TAKEN : CTR_NEW_NTAKEN))
    else $error("fresh entry got wrong counter");
`endif

endmodule

FILE: tb/branch_history_table_update_tb.sv
// Self-checking testbench for the branch history table update block.
module branch_history_table_update_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bhtu_pkg::*;

  localparam logic [1:0]             IDX_MODE_SPARE = 2'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_SPARE_LO   = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_SPARE_HI   = 2'd3;

  // raw one_bit_mode write data; the upper bit must be dropped by the block
  localparam logic [CfgDatWidth-1:0] FLAG_OFF      = 2'd0;
  localparam logic [CfgDatWidth-1:0] FLAG_ON       = 2'd1;
  localparam logic [CfgDatWidth-1:0] FLAG_OFF_WIDE = 2'd2;
  localparam logic [CfgDatWidth-1:0] FLAG_ON_WIDE  = 2'd3;

  localparam int unsigned PHASES           = 7;
  localparam int unsigned ITEMS_PER_PHASE  = 155;
  localparam int unsigned HOT_BRANCHES     = 24;
  localparam int unsigned HOLD_AT_FIRST    = 250;
  localparam int unsigned HOLD_AT_SECOND   = 700;
  localparam int unsigned LONG_HOLD_CYCLES = 60;
  localparam int unsigned TAIL_CYCLES      = 8;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned MAX_REPORTS      = 50;

  typedef struct packed {
    logic [CfgIdxWidth-1:0] idx;
    logic [CfgDatWidth-1:0] data;
  } reg_write_t;

  class counter_predictor;
    bit                  entry_valid[TableDepth];
    logic [CtrWidth-1:0] entry_ctr[TableDepth];
    logic [1:0]          index_mode;
    bit                  one_bit_mode;
    logic [CtrWidth-1:0] expected_counters[$];
    int unsigned         counters_checked;
    int unsigned         errors;

    function new();
      foreach (entry_valid[i]) entry_valid[i] = 1'b0;
      index_mode       = IDX_MODE_PC;
      one_bit_mode     = 1'b0;
      counters_checked = 0;
      errors           = 0;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDatWidth-1:0] data);
      case (idx)
        CFG_INDEX_MODE:   index_mode   = data;
        CFG_ONE_BIT_MODE: one_bit_mode = data[0];
        default: ;
      endcase
    endfunction

    function bhtu_idx_t table_slot(logic [PcWidth-1:0] pc, logic [HistWidth-1:0] hist);
      logic [PcWidth-3:0] word;
      logic [PcWidth-1:0] raw;
      word = pc[PcWidth-1:2];
      case (index_mode)
        // all history bits join the xor, the mask comes after
        IDX_MODE_GSHARE: raw = {2'b00, word} ^ PcWidth'(hist);
        IDX_MODE_CONCAT: raw = PcWidth'({word, hist[HistoryBits-1:0]});
        default:         raw = {2'b00, word};
      endcase
      return raw[IndexBits-1:0];
    endfunction

    function void note_branch(logic [PcWidth-1:0] pc, logic [HistWidth-1:0] hist,
                              logic taken);
      bhtu_idx_t           slot;
      logic [CtrWidth-1:0] ctr;
      slot = table_slot(pc, hist);
      if (!entry_valid[slot]) begin
        entry_valid[slot] = 1'b1;
        ctr = taken ? CTR_NEW_TAKEN : CTR_NEW_NTAKEN;
      end else if (one_bit_mode) begin
        ctr = taken ? CTR_MAX : CTR_MIN;
      end else begin
        ctr = entry_ctr[slot];
        if (taken && ctr != CTR_MAX) ctr = ctr + 1'b1;
        else if (!taken && ctr != CTR_MIN) ctr = ctr - 1'b1;
      end
      entry_ctr[slot] = ctr;
      expected_counters.push_back(ctr);
    endfunction

    function void check_counter(logic [CtrWidth-1:0] got);
      logic [CtrWidth-1:0] want;
      if (expected_counters.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: new_counter expected none, got %0d", $time, got);
        return;
      end
      want = expected_counters.pop_front();
      counters_checked++;
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: new_counter expected %0d, got %0d", $time, want, got);
      end
    endfunction

    function int unsigned pending();
      return expected_counters.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [CfgDatWidth-1:0] cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [PcWidth-1:0]     branch_pc_i;
  logic [HistWidth-1:0]   history_bits_i;
  logic                   outcome_taken_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [CtrWidth-1:0]    new_counter_o;

  counter_predictor     book;
  bit                   idle_on = 1'b0;
  int unsigned          branches_sent = 0;
  int unsigned          reg_writes = 0;
  logic [PcWidth-1:0]   hot_pc[HOT_BRANCHES];
  logic [HistWidth-1:0] hot_hist[HOT_BRANCHES];
  logic                 hot_lean[HOT_BRANCHES];
  logic [PcWidth-1:0]   last_pc = '0;
  logic [HistWidth-1:0] last_hist = '0;

  branch_history_table_update u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .branch_pc_i    (branch_pc_i),
    .history_bits_i (history_bits_i),
    .outcome_taken_i(outcome_taken_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .new_counter_o  (new_counter_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d counters outstanding", $time, book.pending());
        $display("branch_history_table_update_tb failed");
        $finish;
      end
    end
  end

  task automatic send_branch(input logic [PcWidth-1:0] pc, input logic [HistWidth-1:0] hist,
                             input logic taken);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    branch_pc_i     <= pc;
    history_bits_i  <= hist;
    outcome_taken_i <= taken;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_branch(pc, hist, taken);
    branches_sent++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
  endtask

  task automatic program_modes(input logic [CfgDatWidth-1:0] mode_val,
                               input logic [CfgDatWidth-1:0] flag_val);
    reg_write_t writes[$];
    writes.push_back('{CFG_INDEX_MODE, mode_val});
    writes.push_back('{CFG_ONE_BIT_MODE, flag_val});
    // a spare index last, so a wrongly decoded one would clobber the real ones
    writes.push_back('{($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                       CfgDatWidth'($urandom)});
    foreach (writes[k]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= writes[k].idx;
      cfg_data_i  <= writes[k].data;
      do @(posedge clk_i); while (!cfg_ready_o);
      book.write_reg(writes[k].idx, writes[k].data);
      reg_writes++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly revisit a small set of branches so counters saturate and modes
  // switch on live entries; repeat the last branch to hit forwarding.
  function automatic void random_branch(output logic [PcWidth-1:0] pc,
                                        output logic [HistWidth-1:0] hist,
                                        output logic taken);
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      pc    = last_pc;
      hist  = last_hist;
      taken = 1'($urandom_range(0, 1));
    end else if (roll < 72) begin
      pick  = $urandom_range(0, HOT_BRANCHES - 1);
      pc    = hot_pc[pick];
      hist  = hot_hist[pick];
      taken = ($urandom_range(0, 3) != 0) ? hot_lean[pick] : !hot_lean[pick];
    end else begin
      pc    = $urandom;
      hist  = HistWidth'($urandom);
      taken = 1'($urandom_range(0, 1));
    end
    last_pc   = pc;
    last_hist = hist;
  endfunction

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned long_holds;
    stall_left  = 0;
    long_holds  = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) book.check_counter(new_counter_o);
      if (stall_left == 0) begin
        if ((long_holds == 0 && branches_sent >= HOLD_AT_FIRST) ||
            (long_holds == 1 && branches_sent >= HOLD_AT_SECOND)) begin
          // hold long enough for the block to fill and drop in_ready_o
          stall_left = LONG_HOLD_CYCLES;
          long_holds++;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
          stall_left = $urandom_range(1, 4);
        end
      end
      out_ready_i <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin : stimulus
    logic [PcWidth-1:0]     pc;
    logic [HistWidth-1:0]   hist;
    logic                   taken;
    logic [CfgDatWidth-1:0] phase_mode[PHASES];
    logic [CfgDatWidth-1:0] phase_flag[PHASES];
    bit                     phase_idle[PHASES];

    book = new();
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_INDEX_MODE;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    branch_pc_i     <= '0;
    history_bits_i  <= '0;
    outcome_taken_i <= 1'b0;

    foreach (hot_pc[i]) begin
      hot_pc[i]   = $urandom;
      hot_hist[i] = HistWidth'($urandom);
      hot_lean[i] = 1'($urandom_range(0, 1));
    end
    phase_mode = '{IDX_MODE_GSHARE, IDX_MODE_CONCAT, IDX_MODE_PC, IDX_MODE_SPARE,
                   IDX_MODE_GSHARE, IDX_MODE_CONCAT, IDX_MODE_PC};
    phase_flag = '{FLAG_OFF, FLAG_OFF_WIDE, FLAG_ON, FLAG_ON_WIDE,
                   FLAG_ON, FLAG_ON_WIDE, FLAG_OFF};
    phase_idle = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // pc-only index, two-bit counters: new entries, both saturation ends
    send_branch(32'h0000_0000, 10'h000, 1'b1);
    send_branch(32'h0000_0000, 10'h3FF, 1'b1);
    send_branch(32'h0000_0000, 10'h000, 1'b1);
    send_branch(32'h0000_0003, 10'h000, 1'b0);
    send_branch(32'h0000_0000, 10'h000, 1'b0);
    send_branch(32'h0000_0000, 10'h000, 1'b0);
    send_branch(32'h0000_0000, 10'h000, 1'b0);
    send_branch(32'hFFFF_FFFF, 10'h3FF, 1'b0);
    send_branch(32'hFFFF_FFFF, 10'h3FF, 1'b1);
    send_branch(32'hFFFF_F000, 10'h155, 1'b1);
    send_branch(32'h0000_0004, 10'h2AA, 1'b0);
    send_branch(32'hAAAA_AAAA, 10'h155, 1'b1);
    send_branch(32'h5555_5555, 10'h2AA, 1'b0);

    // gshare: high history bits must take part in the xor
    wait_for_results();
    program_modes(IDX_MODE_GSHARE, FLAG_OFF);
    send_branch(32'h0000_0000, 10'h3F0, 1'b1);
    send_branch(32'h0000_0FC0, 10'h3F0, 1'b1);

    // concatenation: only the low history bits count; one-bit updates
    wait_for_results();
    program_modes(IDX_MODE_CONCAT, FLAG_ON);
    send_branch(32'h0000_0010, 10'h0FF, 1'b1);
    send_branch(32'h0000_0010, 10'h00F, 1'b0);
    send_branch(32'h0000_0010, 10'h03F, 1'b1);

    // unused index mode falls back to pc only; wide flag data masked to 1
    wait_for_results();
    program_modes(IDX_MODE_SPARE, FLAG_ON_WIDE);
    send_branch(32'h0000_0004, 10'h3FF, 1'b0);
    send_branch(32'h0000_0004, 10'h000, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      wait_for_results();
      program_modes(phase_mode[p], phase_flag[p]);
      idle_on = phase_idle[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 3 && n == ITEMS_PER_PHASE / 2) wait_for_results();
        random_branch(pc, hist, taken);
        send_branch(pc, hist, taken);
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d branches over %0d mode settings, gaps, stalls and two long holds",
             branches_sent, PHASES + 4);
    $display("%0d counters compared, %0d register writes, %0d errors",
             book.counters_checked, reg_writes, book.errors);
    if (book.errors == 0) begin
      $display("branch_history_table_update_tb passed");
    end else begin
      $display("branch_history_table_update_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/bhtu_pkg.sv
rtl/core/bhtu_index.sv
rtl/core/bhtu_table.sv
rtl/core/branch_history_table_update.sv
tb/branch_history_table_update_tb.sv
